>>> hw/rtl/compensated_double_sum_core_macros.svh
// Assertion macros for the compensated sum RTL (used by cds_back)
`ifndef COMPENSATED_DOUBLE_SUM_CORE_MACROS_SVH
`define COMPENSATED_DOUBLE_SUM_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CDS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CDS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> hw/rtl/cds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cds_pkg;

  localparam logic [63:0] CanonNan = 64'h7FF8_0000_0000_0000;

  // word passed from front to back
  typedef struct packed {
    logic [63:0] value;
    logic        last;
  } item_t;

  // unpacked operand
  typedef struct packed {
    logic        sign;
    logic [10:0] exp;
    logic [52:0] mant;
    logic        is_nan;
    logic        is_inf;
  } unpk_t;

  function automatic unpk_t unpack(input logic [63:0] b);
    unpk_t u;
    u.sign   = b[63];
    u.exp    = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
    u.mant   = {(b[62:52] != 11'd0), b[51:0]};
    u.is_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    u.is_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    return u;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/compensated_double_sum_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake         Word
// input     in         push / full       value_bits_i, last_i
// result    out        pop / empty       total_bits_o
// Each word is taken by the back end, which then makes four dependent passes
// through the 3-stage adder and takes no new word until done; a last word
// makes one more pass, then waits for room in the result queue to write it.
// Reset clears both sums to +0 and empties both queues.
// A two-word input queue and a two-word result queue absorb stalls.
module compensated_double_sum_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] value_bits_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] total_bits_o
);

  logic           fv, take, rwr;
  cds_pkg::item_t item;
  logic [63:0]    rdat;
  logic [63:0]    rq_q [2];
  logic           rwp_q, rrp_q;
  logic [1:0]     rcnt_q;
  logic           rfull, rd;

  cds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .value_bits_i (value_bits_i),
    .last_i       (last_i),
    .vld_o        (fv),
    .item_o       (item),
    .take_i       (take)
  );

  cds_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (fv),
    .item_i     (item),
    .take_o     (take),
    .res_full_i (rfull),
    .res_wr_o   (rwr),
    .res_o      (rdat)
  );

  // result queue
  assign rfull        = (rcnt_q == 2'd2);
  assign empty        = (rcnt_q == 2'd0);
  assign total_bits_o = rq_q[rrp_q];
  assign rd           = pop & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwp_q  <= 1'b0;
      rrp_q  <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      if (rwr) rwp_q <= ~rwp_q;
      if (rd) rrp_q <= ~rrp_q;
      rcnt_q <= rcnt_q + {1'b0, rwr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rwr) rq_q[rwp_q] <= rdat;
  end

endmodule
`default_nettype wire

>>> hw/rtl/cds_fadd.sv
`timescale 1ns / 1ps
`default_nettype none
// Three stage binary64 adder, round to nearest even.
module cds_fadd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_vld_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        sub_i,
  output logic        out_vld_o,
  output logic [63:0] res_o
);

  // stage 1: unpack, swap, align
  cds_pkg::unpk_t ua, ub, big, sml;
  logic        bsgn;
  logic [11:0] ediff;
  logic        swap;
  logic [55:0] sml_al;
  logic [55:0] sml_sh;
  logic        sticky;
  logic [5:0]  shamt;

  always_comb begin
    ua = cds_pkg::unpack(a_i);
    ub = cds_pkg::unpack(b_i);
    bsgn = b_i[63] ^ sub_i;
    ub.sign = bsgn;
    swap = ({ub.exp, ub.mant} > {ua.exp, ua.mant});
    big = swap ? ub : ua;
    sml = swap ? ua : ub;
    ediff = {1'b0, big.exp} - {1'b0, sml.exp};
    shamt = (ediff > 12'd56) ? 6'd56 : ediff[5:0];
    sml_sh = {sml.mant, 3'b000} >> shamt;
    sticky = ({sml.mant, 3'b000} & ~({56{1'b1}} << shamt)) != 56'd0;
    sml_al = {sml_sh[55:1], sml_sh[0] | sticky};
  end

  logic        s1_vld_q;
  logic        s1_sgn_q, s1_eff_sub_q, s1_nan_q, s1_inf_q, s1_inf_sgn_q, s1_zs_q;
  logic [10:0] s1_exp_q;
  logic [55:0] s1_big_q, s1_sml_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sgn_q     <= big.sign;
    s1_eff_sub_q <= ua.sign ^ bsgn;
    s1_nan_q     <= ua.is_nan | ub.is_nan | (ua.is_inf & ub.is_inf & (ua.sign ^ bsgn));
    s1_inf_q     <= ua.is_inf | ub.is_inf;
    s1_inf_sgn_q <= ua.is_inf ? ua.sign : bsgn;
    s1_zs_q      <= ua.sign & bsgn;
    s1_exp_q     <= big.exp;
    s1_big_q     <= {big.mant, 3'b000};
    s1_sml_q     <= sml_al;
  end

  // stage 2: add and count leading zeros
  logic [56:0] sum;
  logic [5:0]  lz;
  always_comb begin
    sum = s1_eff_sub_q ? ({1'b0, s1_big_q} - {1'b0, s1_sml_q})
                       : ({1'b0, s1_big_q} + {1'b0, s1_sml_q});
    lz = 6'd57;
    for (int i = 0; i < 57; i++) begin
      if (sum[i]) lz = 6'(56 - i);
    end
  end

  logic        s2_vld_q;
  logic        s2_sgn_q, s2_nan_q, s2_inf_q, s2_inf_sgn_q, s2_zs_q, s2_zero_q;
  logic [10:0] s2_exp_q;
  logic [56:0] s2_sum_q;
  logic [5:0]  s2_lz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sgn_q     <= s1_sgn_q;
    s2_nan_q     <= s1_nan_q;
    s2_inf_q     <= s1_inf_q;
    s2_inf_sgn_q <= s1_inf_sgn_q;
    s2_zs_q      <= s1_zs_q;
    s2_zero_q    <= (sum == 57'd0);
    s2_exp_q     <= s1_exp_q;
    s2_sum_q     <= sum;
    s2_lz_q      <= lz;
  end

  // stage 3: normalise, round, pack
  logic [12:0] e;
  logic [56:0] nrm;
  logic [5:0]  ls;
  logic [52:0] m;
  logic        g, st, rnd;
  logic [53:0] mr;
  logic [12:0] ef;
  logic [63:0] res;

  always_comb begin
    // value = sum * 2^(exp-55); leading one at bit 56 means exponent exp+1
    // bring the leading one up to bit 56, but not below exponent 1 (subnormal)
    if ({5'd0, s2_lz_q} <= s2_exp_q) begin
      ls = s2_lz_q;
    end else begin
      ls = s2_exp_q[5:0];
    end
    e   = {2'b00, s2_exp_q} + 13'd1 - {7'd0, ls};
    nrm = s2_sum_q << ls;
    m   = nrm[56:4];
    g   = nrm[3];
    st  = nrm[2:0] != 3'd0;
    rnd = g & (st | m[0]);
    mr  = {1'b0, m} + {53'd0, rnd};
    ef  = e;
    if (mr[53]) begin
      ef = e + 13'd1;
      mr = mr >> 1;
    end
    if (s2_nan_q) begin
      res = cds_pkg::CanonNan;
    end else if (s2_inf_q) begin
      res = {s2_inf_sgn_q, 11'h7FF, 52'd0};
    end else if (s2_zero_q) begin
      res = {s2_zs_q, 63'd0};
    end else if (ef >= 13'd2047) begin
      res = {s2_sgn_q, 11'h7FF, 52'd0};
    end else if (!mr[52]) begin
      res = {s2_sgn_q, 11'd0, mr[51:0]};
    end else begin
      res = {s2_sgn_q, ef[10:0], mr[51:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_o <= 1'b0;
    end else begin
      out_vld_o <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res;
  end

endmodule
`default_nettype wire

>>> hw/rtl/cds_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Input side: two-entry queue of incoming words.
module cds_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [63:0]         value_bits_i,
  input  logic                last_i,
  output logic                vld_o,
  output cds_pkg::item_t      item_o,
  input  logic                take_i
);

  cds_pkg::item_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           wr, rd;

  assign full   = (cnt_q == 2'd2);
  assign vld_o  = (cnt_q != 2'd0);
  assign item_o = mem_q[rp_q];
  assign wr     = push & ~full;
  assign rd     = take_i & vld_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= '{value: value_bits_i, last: last_i};
  end

endmodule
`default_nettype wire

>>> hw/rtl/cds_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "compensated_double_sum_core_macros.svh"
// Sequencer: s=r+x, l=s-r, e=x-l, c=c+e; on last t=s+c. One shared adder.
module cds_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  cds_pkg::item_t item_i,
  output logic           take_o,
  input  logic           res_full_i,
  output logic           res_wr_o,
  output logic [63:0]    res_o
);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StSum  = 7'b0000010,
    StLost = 7'b0000100,
    StErr  = 7'b0001000,
    StComp = 7'b0010000,
    StTot  = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e      st_q, st_d;
  logic [63:0] run_q, comp_q, x_q, s_q, l_q, e_q;
  logic        last_q;
  logic        busy_q;
  logic        add_vld, add_done;
  logic [63:0] op_a, op_b, add_res;
  logic        op_sub;

  cds_fadd u_fadd (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (add_vld),
    .a_i       (op_a),
    .b_i       (op_b),
    .sub_i     (op_sub),
    .out_vld_o (add_done),
    .res_o     (add_res)
  );

  assign take_o = (st_q == StIdle) & vld_i;

  // operand selection and issue
  always_comb begin
    op_a   = run_q;
    op_b   = x_q;
    op_sub = 1'b0;
    unique case (st_q)
      StLost: begin op_a = s_q;    op_b = run_q; op_sub = 1'b1; end
      StErr:  begin op_a = x_q;    op_b = l_q;   op_sub = 1'b1; end
      StComp: begin op_a = comp_q; op_b = e_q; end
      StTot:  begin op_a = run_q;  op_b = comp_q; end
      default: ;
    endcase
  end

  assign add_vld = (st_q != StIdle) & (st_q != StOut) & ~busy_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (vld_i) st_d = StSum;
      StSum:  if (add_done) st_d = StLost;
      StLost: if (add_done) st_d = StErr;
      StErr:  if (add_done) st_d = StComp;
      StComp: if (add_done) st_d = last_q ? StTot : StIdle;
      StTot:  if (add_done) st_d = StOut;
      StOut:  if (!res_full_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // state, adder tracking; the old sum is kept until the compensation is in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      busy_q <= 1'b0;
      run_q  <= 64'd0;
      comp_q <= 64'd0;
    end else begin
      st_q <= st_d;
      if (add_done) busy_q <= 1'b0;
      else if (add_vld) busy_q <= 1'b1;
      if (st_q == StComp && add_done) begin
        run_q  <= s_q;
        comp_q <= add_res;
      end
      if (st_q == StOut && !res_full_i) begin
        run_q  <= 64'd0;
        comp_q <= 64'd0;
      end
    end
  end

  // StComp needs err value held; latch it, along with the taken word, s, l and the total
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      x_q    <= item_i.value;
      last_q <= item_i.last;
    end
    if (st_q == StSum && add_done) s_q <= add_res;
    if (st_q == StLost && add_done) l_q <= add_res;
    if (st_q == StErr && add_done) e_q <= add_res;
    if (st_q == StTot && add_done) res_o <= add_res;
  end

  assign res_wr_o = (st_q == StOut) & ~res_full_i;

  `CDS_ASSERT_NEVER(a_take_busy, clk_i, rst_ni, take_o && busy_q, "item taken while adder busy")
  `CDS_ASSERT(a_done_after, clk_i, rst_ni, add_vld |=> busy_q, "adder issue not tracked")
  `CDS_ASSERT_NEVER(a_wr_idle, clk_i, rst_ni, res_wr_o && (st_q != StOut), "result out of sequence")

endmodule
`default_nettype wire

>>> bench/compensated_double_sum_core_tb.sv
`timescale 1ns / 1ps
module compensated_double_sum_core_tb;

  localparam logic [63:0] PosZero = 64'h0000_0000_0000_0000;
  localparam logic [63:0] NegZero = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PosInf  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NegInf  = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] MaxFin  = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinSub  = 64'h0000_0000_0000_0001;
  localparam logic [63:0] MaxSub  = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] SigNan  = 64'hFFF4_0000_0000_1234;
  localparam logic [63:0] OneVal  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] BigVal  = 64'h4341_C379_37E0_8000;  // 1e16

  typedef enum int {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] value_bits_i = '0;
  logic        last_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] total_bits_o;

  idle_mode_e  idle_mode = IdleNone;
  real         acc_sum, acc_comp;
  logic [63:0] totals_due[$];
  int          mismatches = 0;

  compensated_double_sum_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gill-Moller step on simulator doubles (binary64, round to nearest even)
  function automatic void sum_step(input logic [63:0] bits, input logic fin);
    real x, s, lost, total;
    logic [63:0] t;
    x = $bitstoreal(bits);
    s = acc_sum + x;
    lost = s - acc_sum;
    acc_comp = acc_comp + (x - lost);
    acc_sum = s;
    if (fin) begin
      total = acc_sum + acc_comp;
      t = $realtobits(total);
      if (t[62:52] == 11'h7FF && t[51:0] != 52'd0) t = cds_pkg::CanonNan;
      totals_due.push_back(t);
      acc_sum = $bitstoreal(PosZero);
      acc_comp = $bitstoreal(PosZero);
    end
  endfunction

  // present one word, hold until accepted, then maybe idle
  task automatic send_word(input logic [63:0] v, input logic fin);
    int gap;
    push <= 1'b1;
    value_bits_i <= v;
    last_i <= fin;
    do @(posedge clk_i); while (full);
    sum_step(v, fin);
    gap = 0;
    if ((idle_mode == IdleSend || idle_mode == IdleBoth) && $urandom_range(0, 99) < 68)
      gap = $urandom_range(1, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // result side: random stalls and in-order compare
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (totals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected total %h", total_bits_o);
      end else begin
        if (total_bits_o !== totals_due[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("total mismatch: expected %h got %h", totals_due[0], total_bits_o);
        end
        void'(totals_due.pop_front());
      end
    end
    if (idle_mode == IdleRecv || idle_mode == IdleBoth) pop <= ($urandom_range(0, 99) >= 68);
    else pop <= 1'b1;
  end

  function automatic logic [63:0] pick_operand();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      4, 5, 6, 7: b[62:52] = 11'(1023 + $signed($urandom_range(0, 120)) - 60);
      8: begin
        case ($urandom_range(0, 6))
          0: b = PosZero;
          1: b = NegZero;
          2: b = PosInf;
          3: b = NegInf;
          4: b = {b[63], MaxFin[62:0]};
          5: b = {b[63], 11'h7FF, b[51:0] | 52'd1};
          default: b = {b[63], 11'd0, b[51:0]};
        endcase
      end
      9: b[62:52] = 11'd0;
      default: ;
    endcase
    return b;
  endfunction

  task automatic test_extremes();
    send_word(PosZero, 1'b1);
    send_word(PosZero, 1'b0);
    send_word(NegZero, 1'b1);
    send_word(NegZero, 1'b0);
    send_word(NegZero, 1'b1);
    send_word(MaxFin, 1'b0);
    send_word(MaxFin, 1'b1);
    send_word(MinSub, 1'b0);
    send_word(MaxSub, 1'b0);
    send_word({1'b1, MinSub[62:0]}, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
  endtask

  task automatic test_special_cases();
    send_word(PosInf, 1'b0);
    send_word(NegInf, 1'b1);
    send_word(SigNan, 1'b1);
    send_word(PosInf, 1'b1);
    // cancellation that only the compensation recovers
    send_word(BigVal, 1'b0);
    send_word(OneVal, 1'b0);
    send_word({1'b1, BigVal[62:0]}, 1'b1);
    send_word(MaxFin, 1'b0);
    send_word({1'b1, MaxFin[62:0]}, 1'b1);
  endtask

  // well-formed runs of random length, plus a few lone words
  task automatic test_random_runs(input idle_mode_e m, input int words);
    int n, len;
    idle_mode = m;
    n = 0;
    while (n < words) begin
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
      for (int i = 0; i < len; i++) send_word(pick_operand(), i == len - 1);
      n += len;
    end
  endtask

  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    acc_sum = $bitstoreal(PosZero);
    acc_comp = $bitstoreal(PosZero);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special_cases();
    test_random_runs(IdleNone, 180);
    test_random_runs(IdleSend, 180);
    test_random_runs(IdleRecv, 180);
    test_random_runs(IdleBoth, 160);
    push <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
